// File: rtl/core/vkse_pkg.sv
// vkse_pkg: shared types and constants for the VT100 key sequence encoder.
// No dependencies.
package vkse_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 2;   // sequence length 0..3
  localparam int unsigned QDepth = 2;   // sequence queue entries
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [ByteW-1:0] ChEsc    = 8'd27;
  localparam logic [ByteW-1:0] ChEnq    = 8'd5;
  localparam logic [ByteW-1:0] ChBs     = 8'd8;
  localparam logic [ByteW-1:0] ChTab    = 8'd9;
  localparam logic [ByteW-1:0] ChLf     = 8'd10;
  localparam logic [ByteW-1:0] ChCr     = 8'd13;
  localparam logic [ByteW-1:0] ChCtlMsk = 8'h1F;
  localparam logic [ByteW-1:0] PrintLo  = 8'd32;
  localparam logic [ByteW-1:0] PrintHi  = 8'd126;
  localparam logic [ByteW-1:0] CaseBit  = 8'h20;

  // One encoded key: up to three host bytes, first byte in b0.
  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
  } seq_t;

endpackage

// File: rtl/core/vkse_classify.sv
// vkse_classify: front end, maps one key event to a host byte sequence.
// Depends on vkse_pkg.
module vkse_classify import vkse_pkg::*; (
  input  logic [ByteW-1:0] key_code_i,
  input  logic             ctrl_held_i,
  input  logic             alt_held_i,
  input  logic             fn_held_i,
  input  logic             fn2_held_i,
  input  logic             app_cursor_mode_i,
  input  logic             newline_mode_i,
  output seq_t             seq_o
);

  logic [ByteW-1:0] lk;
  logic             printable;
  logic             is_upper;
  logic [ByteW-1:0] f2_code, f1_code;
  logic             f2_hit, f1_hit;

  assign is_upper  = (key_code_i >= "A") && (key_code_i <= "Z");
  assign lk        = is_upper ? (key_code_i | CaseBit) : key_code_i;
  assign printable = (key_code_i >= PrintLo) && (key_code_i <= PrintHi);

  // function key finals
  always_comb begin
    f2_hit  = 1'b1;
    f2_code = "P";
    case (lk)
      "q":     f2_code = "P";
      "w":     f2_code = "Q";
      "a":     f2_code = "R";
      "s":     f2_code = "S";
      default: f2_hit  = 1'b0;
    endcase
  end

  // arrow finals
  always_comb begin
    f1_hit  = 1'b1;
    f1_code = "A";
    case (lk)
      "w":     f1_code = "A";
      "s":     f1_code = "B";
      "a":     f1_code = "D";
      "d":     f1_code = "C";
      default: f1_hit  = 1'b0;
    endcase
  end

  // rules in priority order
  always_comb begin
    seq_o = '0;
    if (fn2_held_i && f2_hit) begin
      seq_o.len = 2'd3;
      seq_o.b0  = ChEsc;
      seq_o.b1  = "O";
      seq_o.b2  = f2_code;
    end else if (fn_held_i && f1_hit) begin
      seq_o.len = 2'd3;
      seq_o.b0  = ChEsc;
      seq_o.b1  = app_cursor_mode_i ? "O" : "[";
      seq_o.b2  = f1_code;
    end else if (ctrl_held_i && printable) begin
      seq_o.len = 2'd1;
      seq_o.b0  = key_code_i & ChCtlMsk;
    end else if (alt_held_i) begin
      seq_o.len = 2'd2;
      seq_o.b0  = ChEsc;
      seq_o.b1  = key_code_i;
    end else if (key_code_i == ChLf || key_code_i == ChCr) begin
      seq_o.len = newline_mode_i ? 2'd2 : 2'd1;
      seq_o.b0  = ChCr;
      seq_o.b1  = ChLf;
    end else if (key_code_i == ChBs || key_code_i == ChTab) begin
      seq_o.len = 2'd1;
      seq_o.b0  = key_code_i;
    end else if (key_code_i == ChEsc || key_code_i == ChEnq) begin
      seq_o.len = 2'd1;
      seq_o.b0  = ChEsc;
    end else if (printable) begin
      seq_o.len = 2'd1;
      seq_o.b0  = key_code_i;
    end
  end

endmodule

// File: rtl/core/vkse_seq_queue.sv
// vkse_seq_queue: short queue of encoded sequences between front and back end.
// Depends on vkse_pkg.
module vkse_seq_queue import vkse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  seq_t wr_data_i,
  input  logic rd_i,
  output seq_t rd_data_o,
  output logic full_o,
  output logic empty_o
);

  seq_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == QCntW'(QDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: rtl/core/vkse_serialiser.sv
// vkse_serialiser: back end, sends one sequence a byte at a time.
// Depends on vkse_pkg.
module vkse_serialiser import vkse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  seq_t             q_data_i,
  input  logic             q_empty_i,
  output logic             q_rd_o,
  input  logic             pop,
  output logic             empty,
  output logic [ByteW-1:0] out_byte_o,
  output logic             last_byte_o
);

  seq_t            cur_q;
  logic [LenW-1:0] idx_q, idx_d;
  logic            valid_q, valid_d;
  logic            take, advance;

  assign empty       = !valid_q;
  assign last_byte_o = (idx_q == cur_q.len - 1'b1);
  assign take        = valid_q && pop;
  assign advance     = take && !last_byte_o;
  // refill when idle or when the final byte leaves
  assign q_rd_o      = !q_empty_i && (!valid_q || (take && last_byte_o));

  always_comb begin
    case (idx_q)
      2'd0:    out_byte_o = cur_q.b0;
      2'd1:    out_byte_o = cur_q.b1;
      default: out_byte_o = cur_q.b2;
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (q_rd_o) begin
      idx_d   = '0;
      valid_d = 1'b1;
    end else if (advance) begin
      idx_d = idx_q + 1'b1;
    end else if (take) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      cur_q <= q_data_i;
    end
  end

endmodule

// File: rtl/core/vt100_key_sequence_encoder.sv
// vt100_key_sequence_encoder: top level, key event in, host bytes out.
// Depends on vkse_pkg, vkse_classify, vkse_seq_queue, vkse_serialiser.
//
// Takes one key event per transaction (key byte, ctrl/alt/fn/fn2 modifiers,
// cursor and newline modes) and delivers the one to three host bytes it
// produces, one byte per result transaction, with last_byte_o marking the
// final byte. Events that produce nothing are swallowed without a result.
// An event is classified in the cycle it is pushed and lands in a two-entry
// sequence queue; the back end then streams one byte per cycle from a held
// output register whenever pop is asserted, so the sustained rate is set by
// the byte-wide result port, and the next sequence is loaded as the final
// byte of the current one is taken. push stays open whilst the queue has
// room, even while a byte is waiting to be popped.
module vt100_key_sequence_encoder import vkse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // event side
  input  logic             push,
  output logic             full,
  input  logic [ByteW-1:0] key_code_i,
  input  logic             ctrl_held_i,
  input  logic             alt_held_i,
  input  logic             fn_held_i,
  input  logic             fn2_held_i,
  input  logic             app_cursor_mode_i,
  input  logic             newline_mode_i,
  // byte side
  output logic             empty,
  input  logic             pop,
  output logic [ByteW-1:0] out_byte_o,
  output logic             last_byte_o
);

  seq_t front_seq;
  seq_t q_seq;
  logic q_wr, q_rd, q_empty;

  vkse_classify u_classify (
    .key_code_i        (key_code_i),
    .ctrl_held_i       (ctrl_held_i),
    .alt_held_i        (alt_held_i),
    .fn_held_i         (fn_held_i),
    .fn2_held_i        (fn2_held_i),
    .app_cursor_mode_i (app_cursor_mode_i),
    .newline_mode_i    (newline_mode_i),
    .seq_o             (front_seq)
  );

  // empty sequences never enter the queue
  assign q_wr = push && (front_seq.len != '0);

  vkse_seq_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (front_seq),
    .rd_i      (q_rd),
    .rd_data_o (q_seq),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  vkse_serialiser u_serialiser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (q_seq),
    .q_empty_i   (q_empty),
    .q_rd_o      (q_rd),
    .pop         (pop),
    .empty       (empty),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

  // A non-final byte taken means more of the same sequence follows at once.
  a_seq_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_byte_o) |=> !empty)
    else $error("sequence broke off before its final byte");

  // The back end only refills when the current byte register is free.
  a_refill_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> (empty || (pop && last_byte_o)))
    else $error("sequence loaded over an unfinished one");

  // A queued sequence is picked up whenever the output side is idle.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !q_empty) |=> !empty)
    else $error("back end idle with a sequence waiting");

endmodule
